[rtl/frtc_pkg.sv]
// shared types, constants and tag decode for the fix required tag checker
`default_nettype none
package frtc_pkg;

  localparam int unsigned NUM_TAGS = 26;

  typedef logic [NUM_TAGS-1:0] tag_mask_t;

  typedef logic [15:0] tag_num_t;

  localparam tag_num_t TAG_TABLE [NUM_TAGS] = '{
    16'd49, 16'd56, 16'd34, 16'd52,
    16'd11, 16'd21, 16'd38, 16'd40, 16'd54, 16'd55, 16'd60,
    16'd37, 16'd41, 16'd44, 16'd59,
    16'd6, 16'd14, 16'd17, 16'd31, 16'd32, 16'd39, 16'd150, 16'd151,
    16'd98, 16'd108,
    16'd45
  };

  localparam tag_mask_t HDR_MASK = 26'h000000F;

  localparam logic [7:0] MSG_NEW_ORDER  = 8'h44;
  localparam logic [7:0] MSG_CANCEL     = 8'h46;
  localparam logic [7:0] MSG_REPLACE    = 8'h47;
  localparam logic [7:0] MSG_EXEC_RPT   = 8'h38;
  localparam logic [7:0] MSG_LOGON      = 8'h41;
  localparam logic [7:0] MSG_REJECT     = 8'h33;
  localparam logic [7:0] MSG_SNAPSHOT   = 8'h57;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_MISSING = 1'b1;

  typedef struct packed {
    tag_num_t   tag_number;
    logic       tag_present;
    logic [7:0] msg_type;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  function automatic tag_mask_t tag_bit(input tag_num_t tag);
    tag_mask_t m;
    m = '0;
    for (int i = 0; i < NUM_TAGS; i++) begin
      if (TAG_TABLE[i] == tag) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic tag_mask_t type_mask(input logic [7:0] t);
    tag_mask_t m;
    case (t)
      MSG_NEW_ORDER: m = 26'h00007F0;
      MSG_CANCEL:    m = 26'h0001F50;
      MSG_REPLACE:   m = 26'h0007FD0;
      MSG_EXEC_RPT:  m = 26'h07F8BD0;
      MSG_LOGON:     m = 26'h1800000;
      MSG_REJECT:    m = 26'h2000000;
      MSG_SNAPSHOT:  m = 26'h0000200;
      default:       m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/frtc_if.sv]
// request channel interfaces for tags in and verdicts out
`default_nettype none
interface frtc_tag_if;
  logic        valid;
  logic        ready;
  logic [15:0] tag_number;
  logic        tag_present;
  logic [7:0]  msg_type;
  logic        end_of_message;

  modport source (output valid, tag_number, tag_present, msg_type, end_of_message,
                  input ready);
  modport sink (input valid, tag_number, tag_present, msg_type, end_of_message,
                output ready);
endinterface

interface frtc_verdict_if;
  logic valid;
  logic ready;
  logic status;

  modport source (output valid, status, input ready);
  modport sink (input valid, status, output ready);
endinterface
`default_nettype wire

[rtl/frtc_in_stage.sv]
// input register for incoming tag requests
`default_nettype none
module frtc_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  frtc_tag_if.sink             tags,
  input  wire logic            advance,
  output frtc_pkg::stage_t     stage
);
  import frtc_pkg::*;

  logic  valid;
  item_t item;

  assign tags.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (tags.ready) begin
      valid <= tags.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tags.ready && tags.valid) begin
      item.tag_number     <= tags.tag_number;
      item.tag_present    <= tags.tag_present;
      item.msg_type       <= tags.msg_type;
      item.end_of_message <= tags.end_of_message;
    end
  end

  assign stage = {valid, item};
endmodule
`default_nettype wire

[rtl/frtc_verdict.sv]
// seen bitmap update, required tag check and result register
`default_nettype none
module frtc_verdict (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire frtc_pkg::stage_t stage,
  output logic                 advance,
  frtc_verdict_if.source       verdict
);
  import frtc_pkg::*;

  tag_mask_t seen_bitmap;
  tag_mask_t seen_bitmap_next;
  tag_mask_t need;
  logic      out_valid;
  logic      status;
  logic      slot_free;

  assign slot_free = !out_valid || verdict.ready;
  assign advance   = stage.valid && (!stage.item.end_of_message || slot_free);

  always_comb begin
    seen_bitmap_next = seen_bitmap;
    if (stage.item.tag_present) begin
      seen_bitmap_next = seen_bitmap | tag_bit(stage.item.tag_number);
    end
    need = HDR_MASK | type_mask(stage.item.msg_type);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_bitmap <= '0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= (advance && stage.item.end_of_message) || (out_valid && !verdict.ready);
      if (advance) begin
        if (stage.item.end_of_message) begin
          seen_bitmap <= '0;
        end else begin
          seen_bitmap <= seen_bitmap_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.item.end_of_message) begin
      status <= ((seen_bitmap_next & need) == need) ? STATUS_OK : STATUS_MISSING;
    end
  end

  assign verdict.valid  = out_valid;
  assign verdict.status = status;
endmodule
`default_nettype wire

[rtl/fix_required_tag_checker.sv]
// Checks FIX messages for required tags. One tag request is taken per cycle unless the
// input stalls; a message ends on a request with end_of_message set. That request is loaded
// into the input register when it is taken, and its status (0 all header and type-required
// tags seen, 1 some missing) is loaded from there into the result register once the result
// slot is free. The type comes from the msg_type of the ending request. Throughput is one
// request per cycle while results are taken; while a verdict is held unread an ending
// request waits in the input register and the input stalls behind it.
`default_nettype none
module fix_required_tag_checker (
  input  wire logic      clk,
  input  wire logic      rst,
  frtc_tag_if.sink       tags,
  frtc_verdict_if.source verdict
);
  import frtc_pkg::*;

  stage_t stage;
  logic   advance;

  frtc_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .tags    (tags),
    .advance (advance),
    .stage   (stage)
  );

  frtc_verdict u_verdict (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (advance),
    .verdict (verdict)
  );
endmodule
`default_nettype wire

[rtl/frtc_checker.sv]
// port level assertions for the fix required tag checker
`default_nettype none
module frtc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        tags_valid,
  input wire logic        tags_ready,
  input wire logic        tags_end_of_message,
  input wire logic        verdict_valid,
  input wire logic        verdict_ready,
  input wire logic        verdict_status
);

  // held verdict stays put
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict_status))
    else $error("verdict changed while stalled");

  // with no verdict pending the input never stalls
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !verdict_valid |-> tags_ready)
    else $error("input stalled with empty result slot");

  // an ending request that is taken is followed by a valid verdict from the result register
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    tags_valid && tags_ready && tags_end_of_message |=> ##1 verdict_valid)
    else $error("missing verdict after end of message");

  // no verdict shortly after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !verdict_valid)
    else $error("verdict right after reset");

endmodule

bind fix_required_tag_checker frtc_checker u_frtc_checker (
  .clk                 (clk),
  .rst                 (rst),
  .tags_valid          (tags.valid),
  .tags_ready          (tags.ready),
  .tags_end_of_message (tags.end_of_message),
  .verdict_valid       (verdict.valid),
  .verdict_ready       (verdict.ready),
  .verdict_status      (verdict.status)
);
`default_nettype wire

[tb/sv/frtc_verdict_check.sv]
// watches the tag and verdict channels, predicts each message verdict and compares
module frtc_verdict_check (
  input  logic    clk,
  input  logic    rst,
  frtc_tag_if     tags,
  frtc_verdict_if verdict,
  output int      mismatches,
  output int      outstanding,
  output int      ok_verdicts,
  output int      missing_verdicts
);
  import frtc_pkg::*;

  tag_mask_t seen_tags;
  tag_mask_t need;
  logic      want_status;
  logic      pending_status [$];
  int        error_count = 0;
  int        ok_count = 0;
  int        missing_count = 0;

  // one slot per required-set tag, ordered by tag number
  function automatic tag_mask_t tag_slot(input int num);
    int idx;
    case (num)
      6:       idx = 0;
      11:      idx = 1;
      14:      idx = 2;
      17:      idx = 3;
      21:      idx = 4;
      31:      idx = 5;
      32:      idx = 6;
      34:      idx = 7;
      37:      idx = 8;
      38:      idx = 9;
      39:      idx = 10;
      40:      idx = 11;
      41:      idx = 12;
      44:      idx = 13;
      45:      idx = 14;
      49:      idx = 15;
      52:      idx = 16;
      54:      idx = 17;
      55:      idx = 18;
      56:      idx = 19;
      59:      idx = 20;
      60:      idx = 21;
      98:      idx = 22;
      108:     idx = 23;
      150:     idx = 24;
      151:     idx = 25;
      default: idx = -1;
    endcase
    return (idx < 0) ? tag_mask_t'(0) : tag_mask_t'(1) << idx;
  endfunction

  function automatic tag_mask_t required_slots(input logic [7:0] mtype);
    tag_mask_t slots;
    slots = tag_slot(49) | tag_slot(56) | tag_slot(34) | tag_slot(52);
    case (mtype)
      MSG_NEW_ORDER: slots |= tag_slot(11) | tag_slot(21) | tag_slot(38) | tag_slot(40) |
                              tag_slot(54) | tag_slot(55) | tag_slot(60);
      MSG_CANCEL:    slots |= tag_slot(11) | tag_slot(37) | tag_slot(38) | tag_slot(41) |
                              tag_slot(54) | tag_slot(55) | tag_slot(60);
      MSG_REPLACE:   slots |= tag_slot(11) | tag_slot(37) | tag_slot(38) | tag_slot(40) |
                              tag_slot(41) | tag_slot(44) | tag_slot(54) | tag_slot(55) |
                              tag_slot(59) | tag_slot(60);
      MSG_EXEC_RPT:  slots |= tag_slot(6) | tag_slot(11) | tag_slot(14) | tag_slot(17) |
                              tag_slot(31) | tag_slot(32) | tag_slot(37) | tag_slot(38) |
                              tag_slot(39) | tag_slot(40) | tag_slot(54) | tag_slot(55) |
                              tag_slot(150) | tag_slot(151);
      MSG_LOGON:     slots |= tag_slot(98) | tag_slot(108);
      MSG_REJECT:    slots |= tag_slot(45);
      MSG_SNAPSHOT:  slots |= tag_slot(55);
      default:       ;
    endcase
    return slots;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("%0t verdict error: %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seen_tags = '0;
      pending_status.delete();
    end else begin
      // retire first, so a verdict is never matched to a request taken on the same edge
      if (verdict.valid && verdict.ready) begin
        if (pending_status.size() == 0) begin
          report_mismatch($sformatf("status %0b with no message pending", verdict.status));
        end else begin
          want_status = pending_status.pop_front();
          if (verdict.status !== want_status) begin
            report_mismatch($sformatf("expected status %0b, got %0b",
                                      want_status, verdict.status));
          end
          if (want_status == STATUS_OK) begin
            ok_count++;
          end else begin
            missing_count++;
          end
        end
      end
      if (tags.valid && tags.ready) begin
        if (tags.tag_present) begin
          seen_tags |= tag_slot(int'(tags.tag_number));
        end
        if (tags.end_of_message) begin
          need = required_slots(tags.msg_type);
          pending_status.push_back(((seen_tags & need) == need) ? STATUS_OK : STATUS_MISSING);
          seen_tags = '0;
        end
      end
    end
    mismatches <= error_count;
    outstanding <= pending_status.size();
    ok_verdicts <= ok_count;
    missing_verdicts <= missing_count;
  end

endmodule

[tb/sv/tb.sv]
// testbench top: clock, reset, tag and verdict stimulus, final verdict
module tb;
  import frtc_pkg::*;

  localparam int ITEM_TARGET = 400;
  localparam int STEADY_ITEMS = 160;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT_CYCLES = 200000;

  localparam logic [7:0] MSG_OTHER = 8'h5A;

  localparam int HDR_TAG_NUMS [4] = '{49, 56, 34, 52};
  localparam logic [7:0] TYPE_CODES [7] = '{MSG_NEW_ORDER, MSG_CANCEL, MSG_REPLACE,
                                            MSG_EXEC_RPT, MSG_LOGON, MSG_REJECT,
                                            MSG_SNAPSHOT};
  // per-type required tags, zero padded
  localparam int TYPE_TAGS [7][14] = '{
    '{11, 21, 38, 40, 54, 55, 60, 0, 0, 0, 0, 0, 0, 0},
    '{11, 37, 38, 41, 54, 55, 60, 0, 0, 0, 0, 0, 0, 0},
    '{11, 37, 38, 40, 41, 44, 54, 55, 59, 60, 0, 0, 0, 0},
    '{6, 11, 14, 17, 31, 32, 37, 38, 39, 40, 54, 55, 150, 151},
    '{98, 108, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{45, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{55, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  logic clk;
  logic rst;

  frtc_tag_if     tags_bus ();
  frtc_verdict_if verdict_bus ();

  int mismatches;
  int outstanding;
  int ok_verdicts;
  int missing_verdicts;

  bit         source_steady = 1'b0;
  bit         sink_steady = 1'b0;
  int         hold_left = 0;
  int         accepted_items = 0;
  tag_num_t   msg_tags [$];
  logic [7:0] mtype;

  fix_required_tag_checker dut (
    .clk     (clk),
    .rst     (rst),
    .tags    (tags_bus),
    .verdict (verdict_bus)
  );

  frtc_verdict_check mon (
    .clk              (clk),
    .rst              (rst),
    .tags             (tags_bus),
    .verdict          (verdict_bus),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .ok_verdicts      (ok_verdicts),
    .missing_verdicts (missing_verdicts)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("timeout with %0d verdicts still pending", outstanding);
    $display("Mismatches found");
    $finish;
  end

  // verdict receiver
  initial begin
    verdict_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        verdict_bus.ready <= 1'b0;
        hold_left--;
      end else if (sink_steady || $urandom_range(0, 99) >= 25) begin
        verdict_bus.ready <= 1'b1;
      end else begin
        verdict_bus.ready <= 1'b0;
      end
    end
  end

  task automatic send_tag(input tag_num_t num, input logic present, input logic [7:0] code,
                          input logic last);
    while (!source_steady && $urandom_range(0, 99) < 25) begin
      tags_bus.valid <= 1'b0;
      @(posedge clk);
    end
    tags_bus.valid <= 1'b1;
    tags_bus.tag_number <= num;
    tags_bus.tag_present <= present;
    tags_bus.msg_type <= code;
    tags_bus.end_of_message <= last;
    do @(posedge clk); while (!tags_bus.ready);
    accepted_items++;
  endtask

  task automatic send_message(input logic [7:0] code, input bit bare_end);
    int last;
    last = msg_tags.size() - 1;
    foreach (msg_tags[i]) begin
      if ($urandom_range(0, 15) == 0) begin
        send_tag(16'($urandom), 1'b0, 8'($urandom), 1'b0);
      end
      if (i == last && !bare_end) begin
        send_tag(msg_tags[i], 1'b1, code, 1'b1);
      end else begin
        send_tag(msg_tags[i], 1'b1, 8'($urandom), 1'b0);
      end
    end
    if (bare_end || msg_tags.size() == 0) begin
      send_tag(16'($urandom), 1'b0, code, 1'b1);
    end
  endtask

  task automatic load_header();
    msg_tags.delete();
    foreach (HDR_TAG_NUMS[h]) msg_tags.push_back(tag_num_t'(HDR_TAG_NUMS[h]));
  endtask

  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 9);
    return (r < 7) ? TYPE_CODES[r] : 8'($urandom);
  endfunction

  task automatic build_message(input logic [7:0] code, input int keep_pct);
    int       j;
    tag_num_t swap;
    tag_num_t extra;
    msg_tags.delete();
    foreach (HDR_TAG_NUMS[h]) begin
      if ($urandom_range(0, 99) < keep_pct) msg_tags.push_back(tag_num_t'(HDR_TAG_NUMS[h]));
    end
    foreach (TYPE_CODES[k]) begin
      if (TYPE_CODES[k] == code) begin
        for (int t = 0; t < 14; t++) begin
          if (TYPE_TAGS[k][t] != 0 && $urandom_range(0, 99) < keep_pct) begin
            msg_tags.push_back(tag_num_t'(TYPE_TAGS[k][t]));
          end
        end
      end
    end
    // noise and repeats
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0:       extra = 16'($urandom);
        1:       extra = 16'($urandom_range(0, 200));
        default: extra = tag_num_t'(TYPE_TAGS[$urandom_range(0, 6)][$urandom_range(0, 13)]);
      endcase
      msg_tags.push_back(extra);
    end
    for (int i = msg_tags.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      swap = msg_tags[i];
      msg_tags[i] = msg_tags[j];
      msg_tags[j] = swap;
    end
  endtask

  initial begin
    rst <= 1'b1;
    tags_bus.valid <= 1'b0;
    tags_bus.tag_number <= '0;
    tags_bus.tag_present <= 1'b0;
    tags_bus.msg_type <= '0;
    tags_bus.end_of_message <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes, nothing from the required set
    send_tag(16'hFFFF, 1'b1, 8'hFF, 1'b0);
    send_tag(16'h0000, 1'b1, 8'h00, 1'b1);
    // end request carries the last needed tag
    load_header();
    msg_tags.push_back(16'd55);
    send_message(MSG_SNAPSHOT, 1'b0);
    // bare end whose tag number would complete the header
    for (int h = 0; h < 3; h++) send_tag(tag_num_t'(HDR_TAG_NUMS[h]), 1'b1, MSG_NEW_ORDER, 1'b0);
    send_tag(16'd52, 1'b0, MSG_OTHER, 1'b1);
    // untyped message, header only, bare end
    load_header();
    send_message(MSG_OTHER, 1'b1);
    // logon with a repeated tag
    load_header();
    msg_tags.push_back(16'd98);
    msg_tags.push_back(16'd49);
    msg_tags.push_back(16'd108);
    send_message(MSG_LOGON, 1'b0);

    // receiver stalls while short messages keep coming
    source_steady = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (30) begin
      msg_tags.delete();
      msg_tags.push_back(tag_num_t'(HDR_TAG_NUMS[$urandom_range(0, 3)]));
      send_message(pick_type(), $urandom_range(0, 1) == 1);
    end

    sink_steady = 1'b1;
    while (accepted_items < ITEM_TARGET) begin
      if (accepted_items >= STEADY_ITEMS) begin
        source_steady = 1'b0;
        sink_steady = 1'b0;
      end
      mtype = pick_type();
      build_message(mtype, ($urandom_range(0, 3) == 0) ? 85 : 100);
      send_message(mtype, $urandom_range(0, 2) == 0);
    end
    tags_bus.valid <= 1'b0;
    sink_steady = 1'b1;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run covered %0d tag requests: %0d complete and %0d incomplete messages,",
             accepted_items, ok_verdicts, missing_verdicts);
    $display("all seven typed checks, other types, bare ends, noise tags and a long stall");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[fix_required_tag_checker.f]
rtl/frtc_pkg.sv
rtl/frtc_if.sv
rtl/frtc_in_stage.sv
rtl/frtc_verdict.sv
rtl/fix_required_tag_checker.sv
rtl/frtc_checker.sv
tb/sv/frtc_verdict_check.sv
tb/sv/tb.sv
